// File: sv/ttc_pkg.sv
// Package for the triangle topological charge pipeline.
// Holds widths, latencies, register indexes, the arctangent table and the
// shared square-root and shift helpers. No dependencies.
package ttc_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int WORK_BITS    = 16;
    localparam int COMP_W       = 16;
    localparam int PAIR_SHIFT   = 2 * FRAC_BITS - WORK_BITS;
    localparam int TRIP_SHIFT   = 3 * FRAC_BITS - WORK_BITS;
    localparam int PF_W         = 19;
    localparam int RAD_W        = 56;
    localparam int ROOT_W       = 28;
    localparam int NUM_W        = 25;
    localparam int RATIO_W      = 18;
    localparam int QUOT_BITS    = 17;
    localparam int ASIN_SQ_STEPS = 17;
    localparam int CORDIC_STEPS = 16;
    localparam int CX_W         = 28;
    localparam int ANG_W        = 25;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 8;

    localparam int FRONT_LAT = 7;
    localparam int RHO_LAT   = ROOT_W;
    localparam int RATIO_LAT = QUOT_BITS + 2;
    localparam int ASIN_LAT  = 2 + ASIN_SQ_STEPS + CORDIC_STEPS + 1;
    localparam int FLAG_LAT  = RATIO_LAT + ASIN_LAT;
    localparam int TOTAL_LAT = FRONT_LAT + RHO_LAT + FLAG_LAT + 1;

    localparam logic [RATIO_W-1:0] UNIT_WORK = RATIO_W'(65536);
    localparam logic [PF_W-1:0]    PF_MAX    = PF_W'(262144);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_SINE = 4'd0,
        CFG_SIGN_TOL = 4'd1
    } cfg_reg_t;

    // Arctangent of 2^-i in turns scaled by 2^24.
    localparam logic signed [ANG_W-1:0] ARC_TABLE [CORDIC_STEPS] = '{
        25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050,
        25'sd166669,  25'sd83416,   25'sd41718,  25'sd20860,
        25'sd10430,   25'sd5215,    25'sd2608,   25'sd1304,
        25'sd652,     25'sd326,     25'sd163,    25'sd81
    };

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sq_state_t;

    // One digit of the restoring integer square root.
    function automatic sq_state_t sq_step(sq_state_t s, logic [1:0] pair);
        sq_state_t   o;
        logic [33:0] cur;
        logic [33:0] trial;
        cur   = {s.rem[31:0], pair};
        trial = {s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // Shift right, truncating toward zero.
    function automatic logic signed [CX_W-1:0] shr_trunc(logic signed [CX_W-1:0] v, int k);
        logic signed [CX_W-1:0] m;
        m = v[CX_W-1] ? -v : v;
        m = m >>> k;
        return v[CX_W-1] ? -m : m;
    endfunction

endpackage

// File: sv/triangle_topological_charge.sv
// Top level of the triangle topological charge pipeline.
// Depends on ttc_pkg, ttc_ratio and ttc_asin.
//
// This block takes the three unit spins of one lattice triangle per item, in
// Q2.14, and returns the triangle's topological charge in Q1.15 together with
// an exceptional flag (zero triple product or a non-positive one plus dot sum)
// and a degenerate flag (rho of zero, charge forced to zero). The pipeline
// accepts one item in every cycle in which it is not stalled; its depth is set
// by the 28-stage square root for rho, the 19-stage restoring dividers and the
// 36-stage arcsine unit built from a 17-stage square root and a 16-stage
// CORDIC. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall at the result side holds every stage
// in place and nothing is lost. The configuration registers select the
// arcsine or arccosine form and the tolerance for the cosine sign fix; write
// them only while the block is idle.
module triangle_topological_charge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From bit 0 up: first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z, each 16 bits signed.
    input  logic [143:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // charge, 16 bits signed.
    output logic [15:0]                         m_tdata,
    // From bit 0 up: exceptional, degenerate.
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ttc_pkg::*;

    typedef struct packed {
        logic signed [NUM_W-1:0] t16;
        logic signed [NUM_W-1:0] s16;
        logic                    exc;
    } side_t;

    localparam logic signed [34:0] ONE_RAW = 35'sd1 <<< (2 * FRAC_BITS);

    // Pipeline control: one enable for every stage.
    logic                 advance;
    logic [TOTAL_LAT-1:0] vld_reg;

    // Configuration registers.
    logic                  use_sine_reg;
    logic [CFG_DATA_W-1:0] tol_reg;

    // Input unpacking.
    logic signed [COMP_W-1:0] a [3];
    logic signed [COMP_W-1:0] b [3];
    logic signed [COMP_W-1:0] c [3];

    // Stage A: all two-term products.
    logic signed [31:0] dp_reg [9];
    logic signed [31:0] cp_reg [6];
    logic signed [COMP_W-1:0] a_a_reg [3];
    // Stage B: inner products and the cross product b x c.
    logic signed [33:0] dot_reg [3];
    logic signed [32:0] cr_reg [3];
    logic signed [COMP_W-1:0] a_b_reg [3];
    // Stage C: triple product terms, pair sums and the dot sum.
    logic signed [48:0] tt_reg [3];
    logic signed [34:0] pr_reg [3];
    logic signed [35:0] sumr_reg;
    // Stage D: triple product, pair factors.
    logic signed [49:0] trip_reg;
    logic [PF_W-1:0]    pf_reg [3];
    logic signed [35:0] sumd_reg;
    logic [PF_W-1:0]    pf_next [3];
    logic [22:0]        pf_round [3];
    // Stage E: first product of the radicand and the rounded numerators.
    logic [37:0]        p12_reg;
    logic [PF_W-1:0]    pf3_reg;
    side_t              side_e_reg;
    side_t              side_e_next;
    logic [49:0]        trip_mag;
    logic [35:0]        sum_mag;
    logic [NUM_W-1:0]   t16_mag;
    logic [NUM_W-1:0]   s16_mag;
    // Stage F and G: split second product and the radicand.
    logic [37:0]        plo_reg;
    logic [37:0]        phi_reg;
    side_t              side_f_reg;
    logic [RAD_W-1:0]   rad_reg;
    side_t              side_g_reg;
    logic [54:0]        rad_half;

    // Square root of the radicand, one result bit per stage.
    sq_state_t          rho_sq_reg [RHO_LAT];
    logic [RAD_W-1:0]   rho_rad_reg [RHO_LAT];
    side_t              rho_side_reg [RHO_LAT];
    logic [ROOT_W-1:0]  root;
    side_t              rho_side;

    // Flags travel alongside the dividers and arcsine units.
    logic [1:0]         flags_reg [FLAG_LAT];

    logic signed [RATIO_W-1:0] ratio_t;
    logic signed [RATIO_W-1:0] ratio_s;
    logic signed [15:0]        qs;
    logic signed [15:0]        as_s;

    // Output stage.
    logic signed [15:0] charge_reg;
    logic signed [15:0] charge_next;
    logic               exc_reg;
    logic               degen_reg;
    logic signed [16:0] qc;
    logic signed [17:0] dsum;
    logic [17:0]        dmag;
    logic               flip;

    assign advance   = !vld_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            use_sine_reg <= 1'b1;
            tol_reg      <= CFG_DATA_W'(1);
        end else begin
            if (advance) begin
                vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_USE_SINE) begin
                    use_sine_reg <= cfg_data[0];
                end else if (cfg_index == CFG_SIGN_TOL) begin
                    tol_reg <= cfg_data;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a[k] = s_tdata[COMP_W*k +: COMP_W];
            b[k] = s_tdata[COMP_W*(3+k) +: COMP_W];
            c[k] = s_tdata[COMP_W*(6+k) +: COMP_W];
        end
    end

    // Pair factors: rounded to 16 fraction bits and clamped to [0, 4].
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pf_round[k] = 23'((35'(pr_reg[k][33:0]) + 35'd2048) >> PAIR_SHIFT);
            if (pr_reg[k][34]) begin
                pf_next[k] = '0;
            end else if (pf_round[k] > 23'(PF_MAX)) begin
                pf_next[k] = PF_MAX;
            end else begin
                pf_next[k] = pf_round[k][PF_W-1:0];
            end
        end
    end

    // Rounded triple product and dot sum, half away from zero.
    always_comb begin
        trip_mag = trip_reg[49] ? 50'(-trip_reg) : 50'(trip_reg);
        sum_mag  = sumd_reg[35] ? 36'(-sumd_reg) : 36'(sumd_reg);
        t16_mag  = NUM_W'((51'(trip_mag) + (51'd1 << (TRIP_SHIFT - 1))) >> TRIP_SHIFT);
        s16_mag  = NUM_W'((37'(sum_mag) + (37'd1 << (PAIR_SHIFT - 1))) >> PAIR_SHIFT);
        side_e_next.t16 = trip_reg[49] ? -$signed(t16_mag) : $signed(t16_mag);
        side_e_next.s16 = sumd_reg[35] ? -$signed(s16_mag) : $signed(s16_mag);
        side_e_next.exc = (trip_reg == '0) || (sumd_reg <= 36'sd0);
        rad_half = 55'(plo_reg) + {phi_reg[35:0], 19'b0};
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < 3; k++) begin
                dp_reg[k]     <= a[k] * b[k];
                dp_reg[3 + k] <= b[k] * c[k];
                dp_reg[6 + k] <= c[k] * a[k];
                a_a_reg[k]    <= a[k];
            end
            cp_reg[0] <= b[1] * c[2];
            cp_reg[1] <= b[2] * c[1];
            cp_reg[2] <= b[2] * c[0];
            cp_reg[3] <= b[0] * c[2];
            cp_reg[4] <= b[0] * c[1];
            cp_reg[5] <= b[1] * c[0];

            for (int k = 0; k < 3; k++) begin
                dot_reg[k] <= 34'(dp_reg[3*k]) + 34'(dp_reg[3*k+1]) + 34'(dp_reg[3*k+2]);
                cr_reg[k]  <= 33'(cp_reg[2*k]) - 33'(cp_reg[2*k+1]);
                a_b_reg[k] <= a_a_reg[k];
            end

            for (int k = 0; k < 3; k++) begin
                tt_reg[k] <= 49'(a_b_reg[k]) * 49'(cr_reg[k]);
                pr_reg[k] <= ONE_RAW + 35'(dot_reg[k]);
            end
            sumr_reg <= 36'(ONE_RAW) + 36'(dot_reg[0]) + 36'(dot_reg[1]) + 36'(dot_reg[2]);

            trip_reg <= 50'(tt_reg[0]) + 50'(tt_reg[1]) + 50'(tt_reg[2]);
            sumd_reg <= sumr_reg;
            for (int k = 0; k < 3; k++) begin
                pf_reg[k] <= pf_next[k];
            end

            p12_reg    <= 38'(pf_reg[0]) * 38'(pf_reg[1]);
            pf3_reg    <= pf_reg[2];
            side_e_reg <= side_e_next;

            plo_reg    <= 38'(p12_reg[18:0]) * 38'(pf3_reg);
            phi_reg    <= 38'(p12_reg[37:19]) * 38'(pf3_reg);
            side_f_reg <= side_e_reg;

            rad_reg    <= {rad_half, 1'b0};
            side_g_reg <= side_f_reg;

            rho_sq_reg[0]   <= sq_step('0, rad_reg[RAD_W-1 -: 2]);
            rho_rad_reg[0]  <= rad_reg << 2;
            rho_side_reg[0] <= side_g_reg;
            for (int k = 1; k < RHO_LAT; k++) begin
                rho_sq_reg[k]   <= sq_step(rho_sq_reg[k-1], rho_rad_reg[k-1][RAD_W-1 -: 2]);
                rho_rad_reg[k]  <= rho_rad_reg[k-1] << 2;
                rho_side_reg[k] <= rho_side_reg[k-1];
            end

            flags_reg[0] <= {(root == '0), rho_side.exc};
            for (int k = 1; k < FLAG_LAT; k++) begin
                flags_reg[k] <= flags_reg[k-1];
            end

            charge_reg <= charge_next;
            exc_reg    <= flags_reg[FLAG_LAT-1][0];
            degen_reg  <= flags_reg[FLAG_LAT-1][1];
        end
    end

    assign root     = rho_sq_reg[RHO_LAT-1].root[ROOT_W-1:0];
    assign rho_side = rho_side_reg[RHO_LAT-1];

    ttc_ratio u_ratio_t (
        .aclk  (aclk),
        .en    (advance),
        .num   (rho_side.t16),
        .den   (root),
        .ratio (ratio_t)
    );

    ttc_ratio u_ratio_s (
        .aclk  (aclk),
        .en    (advance),
        .num   (rho_side.s16),
        .den   (root),
        .ratio (ratio_s)
    );

    ttc_asin u_asin_t (
        .aclk  (aclk),
        .en    (advance),
        .x     (ratio_t),
        .angle (qs)
    );

    ttc_asin u_asin_s (
        .aclk  (aclk),
        .en    (advance),
        .x     (ratio_s),
        .angle (as_s)
    );

    // The cosine answer is a quarter turn minus the arcsine of the sum ratio.
    // When it nearly cancels the sine answer its sign is flipped.
    always_comb begin
        qc   = 17'sd8192 - 17'(as_s);
        dsum = 18'(qc) + 18'(qs);
        dmag = dsum[17] ? 18'(-dsum) : 18'(dsum);
        flip = dmag < 18'(tol_reg);
        if (flags_reg[FLAG_LAT-1][1]) begin
            charge_next = '0;
        end else if (use_sine_reg) begin
            charge_next = qs;
        end else if (flip) begin
            charge_next = 16'(-qc);
        end else begin
            charge_next = 16'(qc);
        end
    end

    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_tdata  = charge_reg;
    assign m_tuser  = {degen_reg, exc_reg};

    // A degenerate triangle always reports zero charge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("degenerate result with nonzero charge");

    // While the result side stalls, no item moves anywhere in the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: sv/ttc_ratio.sv
// Pipelined divider for the triangle charge: rounded num / den clamped to one.
// Restoring division, one quotient bit per stage. Depends on ttc_pkg.
module ttc_ratio (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [ttc_pkg::NUM_W-1:0]    num,
    input  logic        [ttc_pkg::ROOT_W-1:0]   den,
    output logic signed [ttc_pkg::RATIO_W-1:0]  ratio
);
    import ttc_pkg::*;

    localparam int NUMER_W = NUM_W + 24 + 1;
    localparam int REM_W   = ROOT_W + QUOT_BITS;

    logic                 neg_reg [QUOT_BITS+1];
    logic                 ovf_reg [QUOT_BITS+1];
    logic [ROOT_W-1:0]    den_reg [QUOT_BITS+1];
    logic [REM_W-1:0]     rem_reg [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] quo_reg [QUOT_BITS+1];
    logic [REM_W-1:0]     rem_next [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] quo_next [QUOT_BITS+1];
    logic signed [RATIO_W-1:0] ratio_reg;
    logic signed [RATIO_W-1:0] ratio_next;

    logic [NUM_W-1:0]   mag;
    logic [NUMER_W-1:0] numer;
    logic               ovf;
    logic [REM_W-1:0]   trial [QUOT_BITS+1];
    logic [RATIO_W-1:0] qclamp;

    always_comb begin
        mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        numer = {1'b0, mag, 24'b0} + NUMER_W'(den >> 1);
        ovf   = numer >= (NUMER_W'(den) << QUOT_BITS);
        rem_next[0] = ovf ? '0 : numer[REM_W-1:0];
        quo_next[0] = '0;
        trial[0]    = '0;
        for (int k = 1; k <= QUOT_BITS; k++) begin
            trial[k] = REM_W'(den_reg[k-1]) << (QUOT_BITS - k);
            if (rem_reg[k-1] >= trial[k]) begin
                rem_next[k] = rem_reg[k-1] - trial[k];
                quo_next[k] = quo_reg[k-1] | (QUOT_BITS'(1) << (QUOT_BITS - k));
            end else begin
                rem_next[k] = rem_reg[k-1];
                quo_next[k] = quo_reg[k-1];
            end
        end
        if (ovf_reg[QUOT_BITS] || (RATIO_W'(quo_reg[QUOT_BITS]) > UNIT_WORK)) begin
            qclamp = UNIT_WORK;
        end else begin
            qclamp = RATIO_W'(quo_reg[QUOT_BITS]);
        end
        ratio_next = neg_reg[QUOT_BITS] ? -$signed(qclamp) : $signed(qclamp);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= ovf;
            den_reg[0] <= den;
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            for (int k = 1; k <= QUOT_BITS; k++) begin
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            ratio_reg <= ratio_next;
        end
    end

    assign ratio = ratio_reg;

endmodule

// File: sv/ttc_asin.sv
// Pipelined arcsine in turns for the triangle charge, as atan2(x, sqrt(1-x^2)).
// A square-root pipeline feeds a vectoring CORDIC. Depends on ttc_pkg.
module ttc_asin (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [ttc_pkg::RATIO_W-1:0]  x,
    output logic signed [15:0]                  angle
);
    import ttc_pkg::*;

    logic signed [RATIO_W-1:0] x1_reg;
    logic        [16:0]        ax_reg;
    logic signed [RATIO_W-1:0] x2_reg;
    logic        [32:0]        rest_reg;

    sq_state_t                 sq_reg [ASIN_SQ_STEPS];
    logic [33:0]               rs_reg [ASIN_SQ_STEPS];
    logic signed [RATIO_W-1:0] xs_reg [ASIN_SQ_STEPS];

    logic signed [CX_W-1:0]  cx_reg [CORDIC_STEPS];
    logic signed [CX_W-1:0]  cy_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] ag_reg [CORDIC_STEPS];
    logic signed [CX_W-1:0]  cx_next [CORDIC_STEPS];
    logic signed [CX_W-1:0]  cy_next [CORDIC_STEPS];
    logic signed [ANG_W-1:0] ag_next [CORDIC_STEPS];

    logic signed [15:0] angle_reg;
    logic signed [15:0] angle_next;

    logic [33:0] sq_prod;
    logic signed [CX_W-1:0] cx_in [CORDIC_STEPS];
    logic signed [CX_W-1:0] cy_in [CORDIC_STEPS];
    logic signed [ANG_W-1:0] ag_in [CORDIC_STEPS];
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic [ANG_W-1:0] amag;
    logic [15:0] around;

    always_comb begin
        sq_prod = 34'(ax_reg) * 34'(ax_reg);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                cx_in[i] = CX_W'({sq_reg[ASIN_SQ_STEPS-1].root[16:0], 8'b0});
                cy_in[i] = CX_W'(xs_reg[ASIN_SQ_STEPS-1]) <<< 8;
                ag_in[i] = '0;
            end else begin
                cx_in[i] = cx_reg[i-1];
                cy_in[i] = cy_reg[i-1];
                ag_in[i] = ag_reg[i-1];
            end
            dx = shr_trunc(cy_in[i], i);
            dy = shr_trunc(cx_in[i], i);
            if (!cy_in[i][CX_W-1]) begin
                cx_next[i] = cx_in[i] + dx;
                cy_next[i] = cy_in[i] - dy;
                ag_next[i] = ag_in[i] + ARC_TABLE[i];
            end else begin
                cx_next[i] = cx_in[i] - dx;
                cy_next[i] = cy_in[i] + dy;
                ag_next[i] = ag_in[i] - ARC_TABLE[i];
            end
        end
        amag   = ag_reg[CORDIC_STEPS-1][ANG_W-1] ? ANG_W'(-ag_reg[CORDIC_STEPS-1])
                                                 : ANG_W'(ag_reg[CORDIC_STEPS-1]);
        around = 16'((amag + ANG_W'(256)) >> 9);
        angle_next = ag_reg[CORDIC_STEPS-1][ANG_W-1] ? -$signed(around) : $signed(around);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= x;
            ax_reg   <= x[RATIO_W-1] ? 17'(-x) : 17'(x);
            x2_reg   <= x1_reg;
            rest_reg <= 33'((34'd1 << 32) - sq_prod);
            sq_reg[0] <= sq_step('0, {1'b0, rest_reg[32]});
            rs_reg[0] <= {1'b0, rest_reg} << 2;
            xs_reg[0] <= x2_reg;
            for (int k = 1; k < ASIN_SQ_STEPS; k++) begin
                sq_reg[k] <= sq_step(sq_reg[k-1], rs_reg[k-1][33:32]);
                rs_reg[k] <= rs_reg[k-1] << 2;
                xs_reg[k] <= xs_reg[k-1];
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                ag_reg[i] <= ag_next[i];
            end
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// File: tb/sv/triangle_topological_charge_test.sv
// Self-checking testbench for triangle_topological_charge: a directed table of
// triangles, then random spin triples checked against a behavioral charge model.
// Depends on ttc_pkg and the block's RTL only.
module triangle_topological_charge_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ttc_pkg::*;

    localparam int IDLE_PCT    = 30;
    localparam int RANDOM_ITEMS = 930;
    localparam int HANG_LIMIT  = 20000;

    // One expected result: charge plus the two flags.
    typedef struct packed {
        logic signed [15:0] charge;
        logic               exceptional;
        logic               degenerate;
    } charge_t;

    // One directed row: nine components, optional typed-in answer.
    typedef struct {
        logic signed [15:0] comp [9];
        bit                 typed;
        charge_t            answer;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Configuration as the predictor sees it.
    bit        mode_sine = 1'b1;
    bit [7:0]  fix_tolerance = 8'd1;

    charge_t   pending_charges [$];
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit        idle_src = 1'b1;   // randomized idling enabled on the sender
    bit        idle_sink = 1'b1;  // randomized stalling enabled on the receiver
    bit        hold_sink = 1'b0;  // long receiver stall in progress

    triangle_topological_charge dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor of the charge, written in wide integer arithmetic.
    // ---------------------------------------------------------------------
    function automatic longint round_shift(longint v, int k);
        longint m;
        if (k <= 0) return v;
        if (k >= 63) return 0;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (k - 1))) >>> k;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint trunc_shift(longint v, int k);
        return (v < 0) ? -((-v) >>> k) : (v >>> k);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clamp_factor(longint raw);
        longint w;
        w = round_shift(raw, PAIR_SHIFT);
        if (w < 0) w = 0;
        if (w > 4 * 65536) w = 4 * 65536;
        return w;
    endfunction

    function automatic longint clamp_ratio(longint num, longint unsigned den);
        longint unsigned m, q;
        m = (num < 0) ? -num : num;
        if (m > (64'd1 << 36)) m = 64'd1 << 36;
        q = ((m << 24) + (den >> 1)) / den;
        if (q > 65536) q = 65536;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // asin(x)/(2 pi) in output units via vectoring CORDIC.
    function automatic longint arcsine_turns(longint x);
        longint unsigned ax;
        longint cx, cy, ang, dx, dy;
        ax = (x < 0) ? -x : x;
        cx = longint'(isqrt((64'd1 << 32) - ax * ax)) * 256;
        cy = x * 256;
        ang = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = trunc_shift(cy, i);
            dy = trunc_shift(cx, i);
            if (cy >= 0) begin
                cx += dx; cy -= dy; ang += ARC_TABLE[i];
            end else begin
                cx -= dx; cy += dy; ang -= ARC_TABLE[i];
            end
        end
        return round_shift(ang, 9);
    endfunction

    function automatic charge_t triangle_charge(logic signed [15:0] s [9]);
        longint a [3], b [3], c [3];
        longint unit, ab, bc, ca, trip, sum_raw, qs, qc, d;
        longint unsigned rad, rho;
        charge_t r;
        for (int k = 0; k < 3; k++) begin
            a[k] = s[k]; b[k] = s[3 + k]; c[k] = s[6 + k];
        end
        unit = 64'sd1 <<< (2 * FRAC_BITS);
        ab = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        bc = b[0] * c[0] + b[1] * c[1] + b[2] * c[2];
        ca = c[0] * a[0] + c[1] * a[1] + c[2] * a[2];
        trip = a[0] * (b[1] * c[2] - b[2] * c[1])
             + a[1] * (b[2] * c[0] - b[0] * c[2])
             + a[2] * (b[0] * c[1] - b[1] * c[0]);
        sum_raw = unit + ab + bc + ca;
        r.exceptional = (trip == 0) || (sum_raw <= 0);
        r.degenerate = 1'b0;
        r.charge = '0;
        rad = 2 * clamp_factor(unit + ab) * clamp_factor(unit + bc) * clamp_factor(unit + ca);
        rho = isqrt(rad);
        if (rho == 0) begin
            r.degenerate = 1'b1;
        end else begin
            qs = arcsine_turns(clamp_ratio(round_shift(trip, TRIP_SHIFT), rho));
            if (mode_sine) begin
                r.charge = 16'(qs);
            end else begin
                qc = 8192 - arcsine_turns(clamp_ratio(round_shift(sum_raw, PAIR_SHIFT), rho));
                d = qc + qs;
                if (d < 0) d = -d;
                // Cosine answer nearly cancels the sine answer: flip its sign.
                if (d < longint'(fix_tolerance)) qc = -qc;
                r.charge = 16'(qc);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driving tasks. All drives are nonblocking at the rising edge.
    // ---------------------------------------------------------------------
    // The valid stays high between back-to-back items; it only drops when
    // the sender decides to idle or when the stream is drained.
    task automatic send_triangle(logic signed [15:0] s [9], bit typed, charge_t answer);
        charge_t exp_r;
        if (idle_src && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (idle_src && $urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
        exp_r = typed ? answer : triangle_charge(s);
        s_tdata  <= {s[8], s[7], s[6], s[5], s[4], s[3], s[2], s[1], s[0]};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_charges = {pending_charges, exp_r};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_charges.size() != 0) @(posedge aclk);
        repeat (TOTAL_LAT + 10) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_USE_SINE) mode_sine = value[0];
        else fix_tolerance = value;
        @(posedge aclk);
    endtask

    // Random spin: mostly near-unit vectors, sometimes raw 16-bit noise.
    task automatic random_spin(output logic signed [15:0] x, y, z);
        int unsigned sel;
        real fx, fy, fz, n;
        sel = $urandom_range(9);
        if (sel == 0) begin
            x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end else if (sel == 1) begin
            x = 16'sd0; y = 16'sd0; z = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
        end else begin
            fx = $urandom_range(32768) - 16384.0;
            fy = $urandom_range(32768) - 16384.0;
            fz = $urandom_range(32768) - 16384.0;
            n = $sqrt(fx * fx + fy * fy + fz * fz);
            if (n < 1.0) begin
                fx = 16384.0; n = 16384.0;
            end
            x = 16'($rtoi(fx * 16384.0 / n));
            y = 16'($rtoi(fy * 16384.0 / n));
            z = 16'($rtoi(fz * 16384.0 / n));
        end
    endtask

    task automatic random_triangle(bit related);
        logic signed [15:0] s [9];
        for (int k = 0; k < 3; k++) random_spin(s[3 * k], s[3 * k + 1], s[3 * k + 2]);
        // Sometimes reuse a corner so the triple product vanishes.
        if (related) begin
            s[6] = s[0]; s[7] = s[1]; s[8] = s[2];
        end
        send_triangle(s, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------------
    // Result checker: compares every accepted result with the oldest
    // expectation, field by field.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        charge_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_charges.size() == 0) begin
                $display("%0t: unexpected result charge=%0d flags=%b", $realtime,
                         $signed(m_tdata), m_tuser);
                error_count++;
            end else begin
                exp_r = pending_charges.pop_front();
                if (m_tdata !== exp_r.charge) begin
                    $display("%0t: charge expected %0d actual %0d", $realtime,
                             exp_r.charge, $signed(m_tdata));
                    error_count++;
                end
                if (m_tuser[0] !== exp_r.exceptional) begin
                    $display("%0t: exceptional expected %b actual %b", $realtime,
                             exp_r.exceptional, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== exp_r.degenerate) begin
                    $display("%0t: degenerate expected %b actual %b", $realtime,
                             exp_r.degenerate, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a counted long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_sink) m_tready <= 1'b0;
        else if (idle_sink) m_tready <= ($urandom_range(99) >= IDLE_PCT);
        else m_tready <= 1'b1;
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || hold_sink || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > HANG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------------
    initial begin
        row_t rows [$];
        row_t r;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows. Typed answers: degenerate triangles read off directly.
        r.typed = 1'b0; r.answer = '0;
        // All zero spins: 1+dot is one and the triple product is zero.
        r.comp = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        rows = {rows, r};
        r.typed = 1'b1;
        // Two opposite corners: a pair factor vanishes, triangle degenerate.
        r.comp = '{16384, 0, 0, -16384, 0, 0, 0, 16384, 0};
        r.answer = '{16'sd0, 1'b1, 1'b1}; rows = {rows, r};
        // Negative pair factor from oversize anti-parallel spins.
        r.comp = '{-32768, 0, 0, 32767, 0, 0, 0, 0, 16384};
        r.answer = '{16'sd0, 1'b1, 1'b1}; rows = {rows, r};
        r.typed = 1'b0;
        // Orthonormal triad, both handedness: the largest unit-sphere triple product.
        r.comp = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; rows = {rows, r};
        r.comp = '{16384, 0, 0, 0, 0, 16384, 0, 16384, 0}; rows = {rows, r};
        r.comp = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; rows = {rows, r};
        // All corners equal: zero triple product, non-degenerate.
        r.comp = '{0, 0, 16384, 0, 0, 16384, 0, 0, 16384}; rows = {rows, r};
        // Field extremes, ratio beyond one and oversize components.
        r.comp = '{32767, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768};
        rows = {rows, r};
        r.comp = '{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767};
        rows = {rows, r};
        r.comp = '{16384, 16384, 0, 0, 16384, 16384, 16384, 0, 16384}; rows = {rows, r};
        r.comp = '{11585, 11585, 0, -11585, 11585, 0, 0, 0, 16384}; rows = {rows, r};
        r.comp = '{-1, -1, -1, 1, 1, 1, 21845, -21846, 5461}; rows = {rows, r};
        r.comp = '{9459, 9459, 9459, -9459, 9459, 9459, 9459, -9459, 9459};
        rows = {rows, r};

        // The table runs under three settings, default included.
        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 1) begin
                write_reg(CFG_USE_SINE, 8'd0);
                write_reg(CFG_SIGN_TOL, 8'd0);
            end else if (pass == 2) begin
                write_reg(CFG_SIGN_TOL, 8'd255);
            end
            foreach (rows[i]) send_triangle(rows[i].comp, rows[i].typed, rows[i].answer);
            drain();
        end

        // Random part in phases with differing settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_USE_SINE, 8'd1);
                end
                1: begin
                    write_reg(CFG_USE_SINE, 8'hFE);   // upper bits masked: arccosine
                    write_reg(CFG_SIGN_TOL, 8'd1);
                end
                2: begin
                    write_reg(CFG_SIGN_TOL, 8'($urandom));
                    idle_src = 1'b0;                  // long stretch with no idling
                    idle_sink = 1'b0;
                end
                3: begin
                    write_reg(CFG_SIGN_TOL, 8'd255);
                    idle_src = 1'b1;
                    idle_sink = 1'b1;
                end
                default: begin
                    write_reg(CFG_USE_SINE, 8'd1);
                    write_reg(CFG_SIGN_TOL, 8'd0);
                end
            endcase
            if (phase == 3) begin
                // Receiver holds off while the sender keeps offering items.
                hold_sink = 1'b1;
                fork
                    begin
                        repeat (TOTAL_LAT * 3) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                    for (int n = 0; n < 150; n++) random_triangle($urandom_range(9) == 0);
                join
            end else begin
                for (int n = 0; n < RANDOM_ITEMS / 5; n++)
                    random_triangle($urandom_range(9) == 0);
            end
            // Sender pauses until every expected result has come.
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
sv/ttc_pkg.sv
sv/ttc_ratio.sv
sv/ttc_asin.sv
sv/triangle_topological_charge.sv
tb/sv/triangle_topological_charge_test.sv
